>>> hw/rtl/otg_pkg.sv
`timescale 1ns / 1ps

package otg_pkg;

	// Grid limits and pixel coordinate width.
	localparam int MAX_TILES_PER_AXIS = 8;
	localparam int DIM_BITS           = 14;

	// Derived widths: tile index, tile count and the count accumulator.
	localparam int IDX_W = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1;
	localparam int CNT_W = $clog2(MAX_TILES_PER_AXIS + 1);
	localparam int ACC_W = DIM_BITS + $clog2(MAX_TILES_PER_AXIS) + 1;

	// Register port geometry.
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [ACC_W-1:0]    acc_t;

	// Register indexes, taken from the word address.
	typedef enum logic {
		REG_TILE_EDGE    = 1'b0,
		REG_TILE_OVERLAP = 1'b1
	} reg_idx_t;

	localparam dim_t TILE_EDGE_RESET    = dim_t'(512);
	localparam dim_t TILE_OVERLAP_RESET = dim_t'(64);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic count_step;
		logic advance;
	} otg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty_in;
		logic count_done;
		logic last;
	} otg_sts_t;

endpackage

>>> hw/rtl/otg_if.sv
`timescale 1ns / 1ps

// Channel that carries one image size.
interface otg_in_if;
	logic                valid;
	logic                ready;
	otg_pkg::dim_t       frame_width;
	otg_pkg::dim_t       frame_height;

	modport source (output valid, output frame_width, output frame_height, input ready);
	modport sink   (input valid, input frame_width, input frame_height, output ready);
endinterface

// Channel that carries one tile of the layout.
interface otg_out_if;
	logic                valid;
	logic                ready;
	otg_pkg::dim_t       origin_x;
	otg_pkg::dim_t       origin_y;
	otg_pkg::idx_t       grid_row;
	otg_pkg::idx_t       grid_col;
	otg_pkg::cnt_t       count_across;
	otg_pkg::cnt_t       count_down;
	logic                empty_layout;
	logic                count_clipped;
	logic                last_tile;

	modport source (
		output valid, output origin_x, output origin_y, output grid_row, output grid_col,
		output count_across, output count_down, output empty_layout, output count_clipped,
		output last_tile, input ready
	);
	modport sink (
		input valid, input origin_x, input origin_y, input grid_row, input grid_col,
		input count_across, input count_down, input empty_layout, input count_clipped,
		input last_tile, output ready
	);
endinterface

>>> hw/rtl/otg_regs.sv
`timescale 1ns / 1ps

module otg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [otg_pkg::APB_AW-1:0]  paddr,
	input  logic [otg_pkg::APB_DW-1:0]  pwdata,
	output logic [otg_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output otg_pkg::dim_t               tile_edge,
	output otg_pkg::dim_t               tile_overlap
);

	otg_pkg::dim_t     edge_q;
	otg_pkg::dim_t     overlap_q;
	otg_pkg::reg_idx_t reg_idx;

	assign reg_idx = otg_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q    <= otg_pkg::TILE_EDGE_RESET;
			overlap_q <= otg_pkg::TILE_OVERLAP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				otg_pkg::REG_TILE_EDGE:    edge_q    <= pwdata[otg_pkg::DIM_BITS-1:0];
				otg_pkg::REG_TILE_OVERLAP: overlap_q <= pwdata[otg_pkg::DIM_BITS-1:0];
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (reg_idx)
			otg_pkg::REG_TILE_EDGE:
				prdata = otg_pkg::APB_DW'(edge_q);
			otg_pkg::REG_TILE_OVERLAP:
				prdata = otg_pkg::APB_DW'(overlap_q);
		endcase
	end

	assign tile_edge    = edge_q;
	assign tile_overlap = overlap_q;

endmodule

>>> hw/rtl/otg_ctrl.sv
`timescale 1ns / 1ps

module otg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  otg_pkg::otg_sts_t sts,
	output otg_pkg::otg_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_COUNT = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Handshake and datapath commands decoded from the state.
	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = (state_q == ST_EMIT);
	assign cmd.load       = in_valid && (state_q == ST_IDLE);
	assign cmd.count_step = (state_q == ST_COUNT);
	assign cmd.advance    = out_ready && (state_q == ST_EMIT);

	// Next state: an empty layout skips the counting phase.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.empty_in ? ST_EMIT : ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (sts.count_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && sts.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> hw/rtl/otg_dpath.sv
`timescale 1ns / 1ps

module otg_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  otg_pkg::otg_cmd_t cmd,
	output otg_pkg::otg_sts_t sts,
	input  otg_pkg::dim_t     frame_width,
	input  otg_pkg::dim_t     frame_height,
	input  otg_pkg::dim_t     tile_edge,
	input  otg_pkg::dim_t     tile_overlap,
	output otg_pkg::dim_t     origin_x,
	output otg_pkg::dim_t     origin_y,
	output otg_pkg::idx_t     grid_row,
	output otg_pkg::idx_t     grid_col,
	output otg_pkg::cnt_t     count_across,
	output otg_pkg::cnt_t     count_down,
	output logic              empty_layout,
	output logic              count_clipped,
	output logic              last_tile
);

	localparam otg_pkg::idx_t IDX_LAST  = otg_pkg::idx_t'(otg_pkg::MAX_TILES_PER_AXIS - 1);
	localparam otg_pkg::cnt_t CNT_LIMIT = otg_pkg::cnt_t'(otg_pkg::MAX_TILES_PER_AXIS);

	otg_pkg::dim_t ext_x_q, ext_y_q, step_q, pos_x_q, pos_y_q;
	otg_pkg::acc_t acc_x_q, acc_y_q;
	otg_pkg::idx_t iter_q, col_q, row_q;
	otg_pkg::cnt_t cnt_x_q, cnt_y_q;
	logic          done_x_q, done_y_q, clip_q, empty_q;
	logic          col_end, row_end;

	// Preconditions checked on the incoming size.
	assign sts.empty_in = (tile_overlap >= tile_edge) || (frame_width < tile_edge)
		|| (frame_height < tile_edge);
	assign sts.count_done = done_x_q && done_y_q;

	// Position in the grid.
	assign col_end  = (otg_pkg::cnt_t'(col_q) == (cnt_x_q - otg_pkg::cnt_t'(1)));
	assign row_end  = (otg_pkg::cnt_t'(row_q) == (cnt_y_q - otg_pkg::cnt_t'(1)));
	assign sts.last = empty_q || (col_end && row_end);

	// Counting uses a shared step: each cycle every unfinished axis compares its running
	// multiple of the stride with the span beyond the first tile and adds one more stride.
	// Emission moves x one stride per column and y one stride per row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q  <= '0;
			ext_y_q  <= '0;
			step_q   <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			iter_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			cnt_x_q  <= '0;
			cnt_y_q  <= '0;
			done_x_q <= 1'b0;
			done_y_q <= 1'b0;
			clip_q   <= 1'b0;
			empty_q  <= 1'b0;
		end else if (cmd.load) begin
			ext_x_q  <= frame_width - tile_edge;
			ext_y_q  <= frame_height - tile_edge;
			step_q   <= tile_edge - tile_overlap;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			iter_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			cnt_x_q  <= '0;
			cnt_y_q  <= '0;
			done_x_q <= sts.empty_in;
			done_y_q <= sts.empty_in;
			clip_q   <= 1'b0;
			empty_q  <= sts.empty_in;
		end else if (cmd.count_step) begin
			if (!done_x_q) begin
				if (acc_x_q >= otg_pkg::acc_t'(ext_x_q)) begin
					done_x_q <= 1'b1;
					cnt_x_q  <= otg_pkg::cnt_t'(iter_q) + otg_pkg::cnt_t'(1);
				end else if (iter_q == IDX_LAST) begin
					done_x_q <= 1'b1;
					cnt_x_q  <= CNT_LIMIT;
					clip_q   <= 1'b1;
				end else begin
					acc_x_q <= acc_x_q + otg_pkg::acc_t'(step_q);
				end
			end
			if (!done_y_q) begin
				if (acc_y_q >= otg_pkg::acc_t'(ext_y_q)) begin
					done_y_q <= 1'b1;
					cnt_y_q  <= otg_pkg::cnt_t'(iter_q) + otg_pkg::cnt_t'(1);
				end else if (iter_q == IDX_LAST) begin
					done_y_q <= 1'b1;
					cnt_y_q  <= CNT_LIMIT;
					clip_q   <= 1'b1;
				end else begin
					acc_y_q <= acc_y_q + otg_pkg::acc_t'(step_q);
				end
			end
			if (iter_q != IDX_LAST) begin
				iter_q <= iter_q + otg_pkg::idx_t'(1);
			end
		end else if (cmd.advance) begin
			if (col_end) begin
				col_q   <= '0;
				pos_x_q <= '0;
				row_q   <= row_q + otg_pkg::idx_t'(1);
				pos_y_q <= pos_y_q + step_q;
			end else begin
				col_q   <= col_q + otg_pkg::idx_t'(1);
				pos_x_q <= pos_x_q + step_q;
			end
		end
	end

	// The last column and row sit against the image edge.
	assign origin_x      = empty_q ? '0 : (col_end ? ext_x_q : pos_x_q);
	assign origin_y      = empty_q ? '0 : (row_end ? ext_y_q : pos_y_q);
	assign grid_row      = row_q;
	assign grid_col      = col_q;
	assign count_across  = cnt_x_q;
	assign count_down    = cnt_y_q;
	assign empty_layout  = empty_q;
	assign count_clipped = clip_q;
	assign last_tile     = sts.last;

endmodule

>>> hw/rtl/overlapping_tile_grid_generator_unit.sv
`timescale 1ns / 1ps

// Overlapping tile grid generator. Each transfer on dims carries an image size; the block
// answers with the tiles of side tile_edge that cover it, row-major, neighbors sharing
// tile_overlap pixels, the last column and row pinned to the image edge, and last_tile set
// on the final one. A size that cannot hold one tile, or an overlap not below the tile
// edge, gives a single transfer with empty_layout set. One image is handled at a time:
// after the accept, a counting phase steps both axes together to find the tile counts,
// each one more than the quotient ceil((dimension - tile_edge) / stride), that quotient
// capped at MAX_TILES_PER_AXIS - 1 (count_clipped is set when a quotient exceeds the cap);
// an empty layout skips that phase. Then one tile is offered at a time, each held until
// tiles is ready, and dims is ready again the cycle after the last transfer.
// tile_edge sits at byte address 0 and tile_overlap at 4; write them only while idle.
module overlapping_tile_grid_generator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	otg_in_if.sink                      dims,
	otg_out_if.source                   tiles,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [otg_pkg::APB_AW-1:0]  paddr,
	input  logic [otg_pkg::APB_DW-1:0]  pwdata,
	output logic [otg_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	otg_pkg::dim_t     tile_edge;
	otg_pkg::dim_t     tile_overlap;
	otg_pkg::otg_cmd_t cmd;
	otg_pkg::otg_sts_t sts;

	// Configuration registers.
	otg_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tile_edge    (tile_edge),
		.tile_overlap (tile_overlap)
	);

	// Sequencing of one image.
	otg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dims.valid),
		.in_ready  (dims.ready),
		.out_valid (tiles.valid),
		.out_ready (tiles.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Counting and tile position datapath.
	otg_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.frame_width   (dims.frame_width),
		.frame_height  (dims.frame_height),
		.tile_edge     (tile_edge),
		.tile_overlap  (tile_overlap),
		.origin_x      (tiles.origin_x),
		.origin_y      (tiles.origin_y),
		.grid_row      (tiles.grid_row),
		.grid_col      (tiles.grid_col),
		.count_across  (tiles.count_across),
		.count_down    (tiles.count_down),
		.empty_layout  (tiles.empty_layout),
		.count_clipped (tiles.count_clipped),
		.last_tile     (tiles.last_tile)
	);

endmodule

>>> hw/rtl/otg_chk.sv
`timescale 1ns / 1ps

module otg_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          empty_layout,
	input logic          last_tile,
	input otg_pkg::cnt_t count_across,
	input otg_pkg::cnt_t count_down
);

	// A pending tile is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("tile valid dropped before transfer");

	// A new image is never taken while a tile is being offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a tile is pending");

	// After the final tile the output goes quiet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_tile |=> !out_valid)
		else $error("tile offered after the final tile");

	// Input ready drops once an image is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	// An empty layout is a single result with zero counts.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_layout |-> last_tile && (count_across == '0)
			&& (count_down == '0))
		else $error("empty layout with tiles or without last mark");

endmodule

bind overlapping_tile_grid_generator_unit otg_chk u_otg_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (dims.valid),
	.in_ready     (dims.ready),
	.out_valid    (tiles.valid),
	.out_ready    (tiles.ready),
	.empty_layout (tiles.empty_layout),
	.last_tile    (tiles.last_tile),
	.count_across (tiles.count_across),
	.count_down   (tiles.count_down)
);
